/* rtl/les_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_pkg
// shared widths, effect codes, register indexes and delay targets of the led
// effect sequencer
// ----------------------------------------------------------------------------
package les_pkg;

  localparam int LevelW   = 8;
  localparam int PhaseW   = 3;
  localparam int EffectW  = 4;
  localparam int MaskW    = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  typedef logic [LevelW-1:0]  level_t;
  typedef logic [PhaseW-1:0]  phase_t;
  typedef logic [MaskW-1:0]   mask_t;

  // effect codes
  typedef enum logic [EffectW-1:0] {
    EFF_STATIC       = 4'd0,
    EFF_BLINK        = 4'd1,
    EFF_PLANE        = 4'd2,
    EFF_BREATHING    = 4'd3,
    EFF_PAUSED_BREATH = 4'd4,
    EFF_FLASH        = 4'd5,
    EFF_PAUSED_FLASH = 4'd6,
    EFF_HEARTBEAT    = 4'd7,
    EFF_APPEAR       = 4'd8,
    EFF_RAINBOW      = 4'd9
  } effect_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_EFFECT_SELECT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_COLOUR_MASK   = 2'd1;

  // mask bit positions
  localparam int MaskRed   = 2;
  localparam int MaskGreen = 1;
  localparam int MaskBlue  = 0;

  localparam mask_t  MaskReset   = 3'd7;

  // levels and delay targets
  localparam level_t LevelMax    = 8'd255;
  localparam level_t LevelZero   = 8'd0;
  localparam level_t DelayShort  = 8'd20;
  localparam level_t DelayMid    = 8'd40;
  localparam level_t DelayLong   = 8'd60;
  localparam level_t DelayBeat   = 8'd100;
  localparam level_t DelayAppear = 8'd223;

endpackage

/* rtl/les_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_if
// valid/ready channels of the led effect sequencer: tick requests, level
// results and configuration writes
// ----------------------------------------------------------------------------
interface les_tick_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

interface les_level_if;
  logic                 valid;
  logic                 ready;
  les_pkg::level_t      red;
  les_pkg::level_t      green;
  les_pkg::level_t      blue;
  logic                 cycle_done;

  modport source (output valid, output red, output green, output blue,
                  output cycle_done, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input cycle_done, output ready);
endinterface

interface les_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [les_pkg::CfgIdxW-1:0]     index;
  logic [les_pkg::CfgDataW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/led_effect_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_effect_sequencer
// per-tick rgb led effect generator with ten effects and a colour mask
// ----------------------------------------------------------------------------
//
//  channel     dir   payload                          request taken when
//  ---------   ---   ------------------------------   -------------------
//  cfg         in    index, data                      valid (always ready)
//  tick_in     in    advance                          valid & ready
//  level_out   out   red, green, blue, cycle_done     valid & ready
//
//  one request per clock while the output register is empty or being drained;
//  its result appears in the output register on the next cycle
//  the phase/delay/level update is one pass of small logic between the state
//  registers and the output register
//  tick_in is ready whenever the output register is empty or being drained
//  rst (synchronous) clears phase, delay count and levels, selects static
//  with a white mask, and empties the output register
//
module led_effect_sequencer (
  input  logic               clk,
  input  logic               rst,
  les_cfg_if.sink            cfg,
  les_tick_if.sink           tick_in,
  les_level_if.source        level_out
);

  // configuration registers
  logic [les_pkg::EffectW-1:0] effect_select;
  les_pkg::mask_t              colour_mask;

  // effect state
  les_pkg::phase_t phase;
  les_pkg::level_t delay_count;
  les_pkg::level_t red_level;
  les_pkg::level_t green_level;
  les_pkg::level_t blue_level;

  les_pkg::phase_t phase_next;
  les_pkg::level_t delay_count_next;
  les_pkg::level_t red_level_next;
  les_pkg::level_t green_level_next;
  les_pkg::level_t blue_level_next;
  logic            done_next;

  // output register
  logic            out_valid;
  les_pkg::level_t out_red;
  les_pkg::level_t out_green;
  les_pkg::level_t out_blue;
  logic            out_done;

  logic tick_take;
  logic step;

  // configuration writes land immediately; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_select <= les_pkg::EFF_STATIC;
      colour_mask   <= les_pkg::MaskReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        les_pkg::REG_EFFECT_SELECT: effect_select <= cfg.data;
        les_pkg::REG_COLOUR_MASK:   colour_mask   <= cfg.data[les_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  // skid-free output stage: accept while empty or being drained
  assign tick_in.ready = !out_valid || level_out.ready;
  assign tick_take     = tick_in.valid && tick_in.ready;
  assign step          = tick_take && tick_in.advance;

  // one tick of the selected effect's phase machine
  always_comb begin
    les_pkg::level_t dc_up;
    les_pkg::level_t dc_dn;
    les_pkg::level_t r_up;
    les_pkg::level_t r_dn;
    les_pkg::level_t g_up;
    les_pkg::level_t g_dn;
    les_pkg::level_t b_up;
    les_pkg::level_t b_dn;
    les_pkg::phase_t ph_inc;
    logic            m_r;
    logic            m_g;
    logic            m_b;

    dc_up  = delay_count + 8'd1;
    dc_dn  = delay_count - 8'd1;
    r_up   = red_level + 8'd1;
    r_dn   = red_level - 8'd1;
    g_up   = green_level + 8'd1;
    g_dn   = green_level - 8'd1;
    b_up   = blue_level + 8'd1;
    b_dn   = blue_level - 8'd1;
    ph_inc = phase + 3'd1;
    m_r    = colour_mask[les_pkg::MaskRed];
    m_g    = colour_mask[les_pkg::MaskGreen];
    m_b    = colour_mask[les_pkg::MaskBlue];

    // phase without meaning falls back to zero, everything else holds
    phase_next       = '0;
    delay_count_next = delay_count;
    red_level_next   = red_level;
    green_level_next = green_level;
    blue_level_next  = blue_level;
    done_next        = 1'b0;

    case (effect_select)
      les_pkg::EFF_STATIC: begin
        case (phase)
          3'd0: begin
            red_level_next   = m_r ? les_pkg::LevelMax : les_pkg::LevelZero;
            green_level_next = m_g ? les_pkg::LevelMax : les_pkg::LevelZero;
            blue_level_next  = m_b ? les_pkg::LevelMax : les_pkg::LevelZero;
            delay_count_next = '0;
            phase_next       = ph_inc;
          end
          3'd1: begin
            delay_count_next = dc_up;
            done_next        = (dc_up == les_pkg::LevelMax);
            phase_next       = done_next ? '0 : phase;
          end
          default: ;
        endcase
      end

      les_pkg::EFF_BLINK, les_pkg::EFF_PLANE: begin
        case (phase)
          3'd0: begin
            red_level_next   = m_r ? les_pkg::LevelMax : les_pkg::LevelZero;
            green_level_next = m_g ? les_pkg::LevelMax : les_pkg::LevelZero;
            blue_level_next  = m_b ? les_pkg::LevelMax : les_pkg::LevelZero;
            delay_count_next = '0;
            phase_next       = ph_inc;
          end
          3'd1: begin
            delay_count_next = dc_up;
            phase_next       = (dc_up == les_pkg::DelayShort) ? ph_inc : phase;
          end
          3'd2: begin
            red_level_next   = '0;
            green_level_next = '0;
            blue_level_next  = '0;
            phase_next       = ph_inc;
          end
          3'd3: begin
            delay_count_next = dc_up;
            if (effect_select == les_pkg::EFF_BLINK) begin
              done_next  = (dc_up == les_pkg::LevelMax);
              phase_next = done_next ? '0 : phase;
            end else begin
              phase_next = (dc_up == les_pkg::DelayMid) ? ph_inc : phase;
            end
          end
          3'd4: begin
            if (effect_select == les_pkg::EFF_PLANE) begin
              if (m_r) red_level_next   = les_pkg::LevelMax;
              if (m_g) green_level_next = les_pkg::LevelMax;
              if (m_b) blue_level_next  = les_pkg::LevelMax;
              phase_next = ph_inc;
            end
          end
          3'd5: begin
            if (effect_select == les_pkg::EFF_PLANE) begin
              delay_count_next = dc_up;
              phase_next = (dc_up == les_pkg::DelayLong) ? ph_inc : phase;
            end
          end
          3'd6: begin
            if (effect_select == les_pkg::EFF_PLANE) begin
              red_level_next   = '0;
              green_level_next = '0;
              blue_level_next  = '0;
              phase_next       = ph_inc;
            end
          end
          default: begin
            if (effect_select == les_pkg::EFF_PLANE) begin
              delay_count_next = dc_up;
              done_next        = (dc_up == les_pkg::LevelMax);
              phase_next       = done_next ? '0 : phase;
            end
          end
        endcase
      end

      les_pkg::EFF_BREATHING, les_pkg::EFF_PAUSED_BREATH: begin
        case (phase)
          3'd0: begin
            red_level_next   = '0;
            green_level_next = '0;
            blue_level_next  = '0;
            delay_count_next = '0;
            phase_next       = ph_inc;
          end
          3'd1: begin
            if (m_r) red_level_next   = r_up;
            if (m_g) green_level_next = g_up;
            if (m_b) blue_level_next  = b_up;
            delay_count_next = dc_up;
            phase_next       = (dc_up == les_pkg::LevelMax) ? ph_inc : phase;
          end
          3'd2: begin
            if (m_r) red_level_next   = r_dn;
            if (m_g) green_level_next = g_dn;
            if (m_b) blue_level_next  = b_dn;
            delay_count_next = dc_dn;
            if (effect_select == les_pkg::EFF_BREATHING) begin
              done_next  = (dc_dn == les_pkg::LevelZero);
              phase_next = done_next ? '0 : phase;
            end else begin
              phase_next = (dc_dn == les_pkg::LevelZero) ? ph_inc : phase;
            end
          end
          3'd3: begin
            if (effect_select == les_pkg::EFF_PAUSED_BREATH) begin
              delay_count_next = dc_up;
              phase_next = (dc_up == les_pkg::LevelMax) ? ph_inc : phase;
            end
          end
          3'd4: begin
            if (effect_select == les_pkg::EFF_PAUSED_BREATH) begin
              delay_count_next = dc_dn;
              done_next        = (dc_dn == les_pkg::LevelZero);
              phase_next       = done_next ? '0 : phase;
            end
          end
          default: ;
        endcase
      end

      les_pkg::EFF_FLASH, les_pkg::EFF_PAUSED_FLASH: begin
        case (phase)
          3'd0: begin
            red_level_next   = m_r ? les_pkg::LevelMax : les_pkg::LevelZero;
            green_level_next = m_g ? les_pkg::LevelMax : les_pkg::LevelZero;
            blue_level_next  = m_b ? les_pkg::LevelMax : les_pkg::LevelZero;
            delay_count_next = les_pkg::LevelMax;
            phase_next       = ph_inc;
          end
          3'd1: begin
            if (m_r) red_level_next   = r_dn;
            if (m_g) green_level_next = g_dn;
            if (m_b) blue_level_next  = b_dn;
            delay_count_next = dc_dn;
            if (effect_select == les_pkg::EFF_FLASH) begin
              done_next  = (dc_dn == les_pkg::LevelZero);
              phase_next = done_next ? '0 : phase;
            end else begin
              phase_next = (dc_dn == les_pkg::LevelZero) ? ph_inc : phase;
            end
          end
          3'd2: begin
            if (effect_select == les_pkg::EFF_PAUSED_FLASH) begin
              delay_count_next = dc_up;
              done_next        = (dc_up == les_pkg::LevelMax);
              phase_next       = done_next ? '0 : phase;
            end
          end
          default: ;
        endcase
      end

      les_pkg::EFF_HEARTBEAT, les_pkg::EFF_APPEAR: begin
        case (phase)
          3'd0: begin
            red_level_next   = m_r ? les_pkg::LevelMax : les_pkg::LevelZero;
            green_level_next = m_g ? les_pkg::LevelMax : les_pkg::LevelZero;
            blue_level_next  = m_b ? les_pkg::LevelMax : les_pkg::LevelZero;
            delay_count_next = les_pkg::LevelMax;
            phase_next       = ph_inc;
          end
          3'd1: begin
            if (m_r) red_level_next   = r_dn;
            if (m_g) green_level_next = g_dn;
            if (m_b) blue_level_next  = b_dn;
            delay_count_next = dc_dn;
            phase_next       = (dc_dn == les_pkg::DelayBeat) ? ph_inc : phase;
          end
          3'd2: begin
            if (effect_select == les_pkg::EFF_HEARTBEAT) begin
              if (m_r) red_level_next   = les_pkg::LevelMax;
              if (m_g) green_level_next = les_pkg::LevelMax;
              if (m_b) blue_level_next  = les_pkg::LevelMax;
              delay_count_next = les_pkg::LevelMax;
              phase_next       = ph_inc;
            end else begin
              delay_count_next = dc_up;
              phase_next = (dc_up == les_pkg::LevelMax) ? ph_inc : phase;
            end
          end
          3'd3: begin
            if (effect_select == les_pkg::EFF_HEARTBEAT) begin
              if (m_r) red_level_next   = r_dn;
              if (m_g) green_level_next = g_dn;
              if (m_b) blue_level_next  = b_dn;
              delay_count_next = dc_dn;
              done_next        = (dc_dn == les_pkg::LevelZero);
              phase_next       = done_next ? '0 : phase;
            end else begin
              if (m_r) red_level_next   = les_pkg::LevelMax;
              if (m_g) green_level_next = les_pkg::LevelMax;
              if (m_b) blue_level_next  = les_pkg::LevelMax;
              delay_count_next = les_pkg::LevelMax;
              phase_next       = ph_inc;
            end
          end
          3'd4: begin
            if (effect_select == les_pkg::EFF_APPEAR) begin
              if (m_r) red_level_next   = r_dn;
              if (m_g) green_level_next = g_dn;
              if (m_b) blue_level_next  = b_dn;
              delay_count_next = dc_dn;
              phase_next = (dc_dn == les_pkg::LevelZero) ? ph_inc : phase;
            end
          end
          3'd5: begin
            if (effect_select == les_pkg::EFF_APPEAR) begin
              delay_count_next = dc_up;
              done_next        = (dc_up == les_pkg::DelayAppear);
              phase_next       = done_next ? '0 : phase;
            end
          end
          default: ;
        endcase
      end

      // rainbow walks the colour wheel and ignores the mask
      les_pkg::EFF_RAINBOW: begin
        case (phase)
          3'd0: begin
            red_level_next   = '0;
            green_level_next = '0;
            blue_level_next  = les_pkg::LevelMax;
            phase_next       = ph_inc;
          end
          3'd1: begin
            red_level_next = r_up;
            phase_next     = (r_up == les_pkg::LevelMax) ? ph_inc : phase;
          end
          3'd2: begin
            blue_level_next = b_dn;
            phase_next      = (b_dn == les_pkg::LevelZero) ? ph_inc : phase;
          end
          3'd3: begin
            green_level_next = g_up;
            phase_next       = (g_up == les_pkg::LevelMax) ? ph_inc : phase;
          end
          3'd4: begin
            red_level_next = r_dn;
            phase_next     = (r_dn == les_pkg::LevelZero) ? ph_inc : phase;
          end
          3'd5: begin
            blue_level_next = b_up;
            phase_next      = (b_up == les_pkg::LevelMax) ? ph_inc : phase;
          end
          3'd6: begin
            green_level_next = g_dn;
            done_next        = (g_dn == les_pkg::LevelZero);
            phase_next       = done_next ? '0 : phase;
          end
          default: ;
        endcase
      end

      // codes ten to fifteen: no effect, phase back to zero
      default: ;
    endcase
  end

  // effect state moves only on an advancing tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      delay_count <= '0;
      red_level   <= '0;
      green_level <= '0;
      blue_level  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      delay_count <= delay_count_next;
      red_level   <= red_level_next;
      green_level <= green_level_next;
      blue_level  <= blue_level_next;
    end
  end

  // result register: levels after the tick, or the held levels without advance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_take) begin
      out_valid <= 1'b1;
    end else if (level_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      out_red   <= tick_in.advance ? red_level_next   : red_level;
      out_green <= tick_in.advance ? green_level_next : green_level;
      out_blue  <= tick_in.advance ? blue_level_next  : blue_level;
      out_done  <= tick_in.advance && done_next;
    end
  end

  assign level_out.valid      = out_valid;
  assign level_out.red        = out_red;
  assign level_out.green      = out_green;
  assign level_out.blue       = out_blue;
  assign level_out.cycle_done = out_done;

`ifndef ASSERT_OFF
  // a waiting result always shows the state it left behind
  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    level_out.valid |-> (level_out.red == red_level) && (level_out.green == green_level)
                        && (level_out.blue == blue_level))
    else $error("result levels differ from held levels");

  // end of cycle leaves the phase machine at its start
  a_done_phase_zero: assert property (@(posedge clk) disable iff (rst)
    level_out.valid && level_out.cycle_done |-> phase == '0)
    else $error("cycle_done without phase back at zero");

  // a request without advance changes nothing and ends no cycle
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    tick_take && !tick_in.advance |=> level_out.valid && !level_out.cycle_done
                                      && $stable(phase) && $stable(delay_count))
    else $error("non-advancing request changed the effect state");
`endif

endmodule
